// ===== sv/tfb_pkg.sv =====
// Package for the terminator-flushed byte buffer.
// Shared constants, register codes and the result item type; no dependencies.
package tfb_pkg;

   localparam int BUFFER_DEPTH_DEF = 64;
   localparam int MAX_TERM_LEN_DEF = 8;
   localparam int CMD_QUEUE_DEPTH  = 4;
   localparam int OUT_QUEUE_DEPTH  = 4;

   localparam int BYTE_W     = 8;
   localparam int CAP_W      = 7;
   localparam int TLEN_W     = 4;
   localparam int TERM_W     = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
   localparam logic [TLEN_W-1:0] TLEN_RESET = 4'd1;
   localparam logic [TERM_W-1:0] TERM_RESET = 64'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_BYTES  = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
      logic              empty_res;
   } rsp_item_type;

endpackage

// ===== sv/tfb_intf.sv =====
// Valid/ready channel interfaces for request and response items.
// Depends on tfb_pkg.
interface tfb_req_intf import tfb_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              command;
   logic [BYTE_W-1:0] data_byte;
   modport source (output valid, command, data_byte, input ready);
   modport sink (input valid, command, data_byte, output ready);
endinterface

interface tfb_rsp_intf import tfb_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;
   logic              empty_res;
   modport source (output valid, out_byte, last, empty_res, input ready);
   modport sink (input valid, out_byte, last, empty_res, output ready);
endinterface

// ===== sv/terminator_flushed_byte_buffer_core.sv =====
// Terminator-flushed byte buffer, top level. Write items are taken one per cycle
// while the 4-entry command queue has room; a flush of n bytes holds the back end
// for one RAM read per byte, then the store; an empty flush for one empty result
// and the store. A result passes the command queue, RAM read and result queue.
// Synchronous active-high reset clears the fill count, queues and back-end state.
module terminator_flushed_byte_buffer_core import tfb_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
   parameter int MAX_TERM_LEN = MAX_TERM_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   tfb_req_intf.sink             req_bus,
   tfb_rsp_intf.source           rsp_bus
);

   localparam int CW  = $clog2(BUFFER_DEPTH + 1);
   localparam int AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int EW  = 2 + CW + AW + BYTE_W;
   localparam int QCW = $clog2(CMD_QUEUE_DEPTH + 1);
   localparam int OCW = $clog2(OUT_QUEUE_DEPTH + 1);
   localparam int RW  = $bits(rsp_item_type);

   logic              cmd_push, cmd_pop, cmd_full, cmd_empty;
   logic [EW-1:0]     cmd_in, cmd_head;
   logic [QCW-1:0]    cmd_count;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] ram_wdata, ram_rdata;
   logic              out_push, out_full, out_empty, out_pop;
   logic [OCW-1:0]    out_count;
   rsp_item_type      out_item, out_head;

   tfb_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .MAX_TERM_LEN (MAX_TERM_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in)
   );

   tfb_queue #(
      .WIDTH (EW),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .head_data (cmd_head),
      .full      (cmd_full),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   tfb_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .OUT_DEPTH    (OUT_QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty && (cmd_count != '0)),
      .cmd_data  (cmd_head),
      .cmd_pop   (cmd_pop),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .out_count (out_count),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   tfb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_buffer_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tfb_queue #(
      .WIDTH (RW),
      .DEPTH (OUT_QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .pop       (out_pop),
      .head_data (out_head),
      .full      (out_full),
      .empty     (out_empty),
      .count     (out_count)
   );

   assign out_pop           = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid     = !out_empty && !(out_full && out_count == '0);
   assign rsp_bus.out_byte  = out_head.out_byte;
   assign rsp_bus.last      = out_head.last;
   assign rsp_bus.empty_res = out_head.empty_res;

endmodule

// ===== sv/tfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/tfb_queue.sv =====
// Small FIFO of register slots, used for the command queue and the result queue.
// No dependencies.
module tfb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty,
   output logic [CW-1:0]    count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== sv/tfb_front.sv =====
// Front end: config registers, fill tracking and terminator detection.
// Turns each request item into a queued flush/store command. Depends on tfb_pkg.
module tfb_front import tfb_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
   parameter int MAX_TERM_LEN = MAX_TERM_LEN_DEF,
   localparam int CW = $clog2(BUFFER_DEPTH + 1),
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
   localparam int EW = 2 + CW + AW + BYTE_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   tfb_req_intf.sink             req_bus,
   input  logic                  cmd_full,
   output logic                  cmd_push,
   output logic [EW-1:0]         cmd_data
);

   localparam int HW = (MAX_TERM_LEN > 1) ? $clog2(MAX_TERM_LEN) : 1;

   logic [CAP_W-1:0]  cap_ff;
   logic [TLEN_W-1:0] tlen_ff;
   logic [TERM_W-1:0] term_ff;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [BYTE_W-1:0] hist_ff [MAX_TERM_LEN];

   logic [CAP_W-1:0]  cap_eff;
   logic [TLEN_W-1:0] tlen_eff;
   logic              term_hit, at_cap, flush, store;
   logic [CW-1:0]     base;
   logic              accept;

   assign accept         = req_bus.valid && req_bus.ready;
   assign req_bus.ready  = !cmd_full;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (cap_ff > CAP_W'(BUFFER_DEPTH)) begin
         cap_eff = CAP_W'(BUFFER_DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
      if (tlen_ff == '0) begin
         tlen_eff = TLEN_W'(1);
      end else if (tlen_ff > TLEN_W'(MAX_TERM_LEN)) begin
         tlen_eff = TLEN_W'(MAX_TERM_LEN);
      end else begin
         tlen_eff = tlen_ff;
      end
   end

   // hist_ff[0] is the newest byte; terminator byte i sits at hist[tlen-1-i]
   always_comb begin
      term_hit = (CAP_W'(fill_ff) >= CAP_W'(tlen_eff));
      for (int i = 0; i < MAX_TERM_LEN; i++) begin
         if (i < int'(tlen_eff)) begin
            if (hist_ff[HW'(int'(tlen_eff) - 1 - i)] != term_ff[BYTE_W*i +: BYTE_W]) begin
               term_hit = 1'b0;
            end
         end
      end
   end

   assign at_cap = (CAP_W'(fill_ff) >= cap_eff);

   always_comb begin
      if (req_bus.command == CMD_CLOSE) begin
         flush = 1'b1;
         store = 1'b0;
         base  = '0;
      end else begin
         flush = at_cap || term_hit;
         base  = flush ? '0 : fill_ff;
         store = (base < CW'(BUFFER_DEPTH));
      end
      fill_in = store ? base + 1'b1 : base;
   end

   assign cmd_push = accept;
   assign cmd_data = {flush, store, fill_ff, base[AW-1:0], req_bus.data_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         tlen_ff <= TLEN_RESET;
         term_ff <= TERM_RESET;
         fill_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CAPACITY:    cap_ff  <= csr_wdata[CAP_W-1:0];
               CSR_TERM_LENGTH: tlen_ff <= csr_wdata[TLEN_W-1:0];
               CSR_TERM_BYTES:  term_ff <= csr_wdata[TERM_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store) begin
         hist_ff[0] <= req_bus.data_byte;
         for (int i = 1; i < MAX_TERM_LEN; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

endmodule

// ===== sv/tfb_back.sv =====
// Back end: executes queued commands, draining the buffer RAM oldest first
// and then storing the new byte if the command has one. Depends on tfb_pkg.
module tfb_back import tfb_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
   parameter int OUT_DEPTH    = OUT_QUEUE_DEPTH,
   localparam int CW  = $clog2(BUFFER_DEPTH + 1),
   localparam int AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
   localparam int EW  = 2 + CW + AW + BYTE_W,
   localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  logic [EW-1:0]     cmd_data,
   output logic              cmd_pop,
   output logic              ram_we,
   output logic [AW-1:0]     ram_waddr,
   output logic [BYTE_W-1:0] ram_wdata,
   output logic [AW-1:0]     ram_raddr,
   input  logic [BYTE_W-1:0] ram_rdata,
   input  logic [OCW-1:0]    out_count,
   output logic              out_push,
   output rsp_item_type      out_item
);

   logic              h_flush, h_store;
   logic [CW-1:0]     h_count;
   logic [AW-1:0]     h_addr;
   logic [BYTE_W-1:0] h_byte;

   logic [CW-1:0] idx_ff, idx_in;
   logic          drained_ff, drained_in;
   logic          pend_ff, pend_last_ff, pend_empty_ff;
   logic          issue, issue_last, credit;

   assign {h_flush, h_store, h_count, h_addr, h_byte} = cmd_data;

   assign credit = ((OCW+1)'(out_count) + (OCW+1)'(pend_ff)) < (OCW+1)'(OUT_DEPTH);

   always_comb begin
      issue      = 1'b0;
      issue_last = 1'b0;
      idx_in     = idx_ff;
      drained_in = drained_ff;
      cmd_pop    = 1'b0;
      ram_we     = 1'b0;
      if (cmd_valid && h_flush && !drained_ff) begin
         if (credit) begin
            issue      = 1'b1;
            issue_last = (h_count == '0) || (idx_ff + 1'b1 == h_count);
            idx_in     = issue_last ? '0 : idx_ff + 1'b1;
            drained_in = issue_last;
         end
      end else if (cmd_valid) begin
         ram_we     = h_store;
         cmd_pop    = 1'b1;
         drained_in = 1'b0;
      end
   end

   assign ram_raddr = idx_ff[AW-1:0];
   assign ram_waddr = h_addr;
   assign ram_wdata = h_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         drained_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         drained_ff <= drained_in;
         pend_ff    <= issue;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff  <= issue_last;
      pend_empty_ff <= (h_count == '0);
   end

   assign out_push           = pend_ff;
   assign out_item.out_byte  = pend_empty_ff ? '0 : ram_rdata;
   assign out_item.last      = pend_last_ff;
   assign out_item.empty_res = pend_empty_ff;

endmodule
